// ===== rtl/fssu_pkg.sv =====
// Shared types, constants and the microprogram of the free slot set.
package fssu_pkg;

  localparam int SLOTS  = 64;
  localparam int DEPTH  = SLOTS + 1;
  localparam int SLOT_W = 6;
  localparam int PW     = 7;
  localparam int HI_W   = PW + 1;
  localparam int CNT_W  = 7;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;
  localparam int PC_W   = 4;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_UNDO  = 2'd1;
  localparam logic [OP_W-1:0] OP_FIRST = 2'd2;
  localparam logic [OP_W-1:0] OP_NEXT  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

  // Microprogram step addresses.
  localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
  localparam logic [PC_W-1:0] PC_PUT0 = 4'd1;
  localparam logic [PC_W-1:0] PC_SPL1 = 4'd2;
  localparam logic [PC_W-1:0] PC_SPL2 = 4'd3;
  localparam logic [PC_W-1:0] PC_UND0 = 4'd4;
  localparam logic [PC_W-1:0] PC_UND1 = 4'd5;
  localparam logic [PC_W-1:0] PC_FST0 = 4'd6;
  localparam logic [PC_W-1:0] PC_FST1 = 4'd7;
  localparam logic [PC_W-1:0] PC_NXT0 = 4'd8;
  localparam logic [PC_W-1:0] PC_NXT1 = 4'd9;

  // Forward table read address select.
  localparam logic [1:0] FRD_NONE = 2'd0;
  localparam logic [1:0] FRD_F1   = 2'd1;
  localparam logic [1:0] FRD_IDX  = 2'd2;
  localparam logic [1:0] FRD_HEAD = 2'd3;

  // Backward table read address select.
  localparam logic [1:0] BRD_NONE = 2'd0;
  localparam logic [1:0] BRD_F    = 2'd1;
  localparam logic [1:0] BRD_HI   = 2'd2;

  // Undo stack action.
  localparam logic [1:0] STK_NONE = 2'd0;
  localparam logic [1:0] STK_PUSH = 2'd1;
  localparam logic [1:0] STK_POP  = 2'd2;

  // Result unit operation.
  localparam logic [2:0] RES_KEEP     = 3'd0;
  localparam logic [2:0] RES_PUT      = 3'd1;
  localparam logic [2:0] RES_UNDO_CHK = 3'd2;
  localparam logic [2:0] RES_UNDO_F   = 3'd3;
  localparam logic [2:0] RES_FIRST    = 3'd4;
  localparam logic [2:0] RES_NEXT_CHK = 3'd5;
  localparam logic [2:0] RES_NEXT     = 3'd6;

  // Jump condition.
  localparam logic [1:0] CND_NEVER  = 2'd0;
  localparam logic [1:0] CND_ALWAYS = 2'd1;
  localparam logic [1:0] CND_QUIT   = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [SLOT_W-1:0] field_index;
  } in_item_t;

  typedef struct packed {
    logic [PW-1:0]    field_out;
    logic [CNT_W-1:0] free_count;
    logic [ST_W-1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [1:0]      frd;
    logic [1:0]      brd;
    logic            lat;
    logic            wr;
    logic [1:0]      stk;
    logic            fsrc;
    logic [2:0]      res;
    logic [1:0]      cnd;
    logic [PC_W-1:0] tgt_t;
    logic [PC_W-1:0] tgt_f;
  } ctrl_t;

  typedef struct packed {
    logic accept;
    logic step_en;
    logic done;
  } seq_stat_t;

  typedef struct packed {
    logic          rd_en;
    logic [PW-1:0] rd_addr;
    logic          wr_en;
    logic [PW-1:0] wr_addr;
    logic [PW-1:0] wr_data;
  } tbl_req_t;

  // Control store. A step whose selected target is the idle address is the last one.
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    c = '0;
    c.tgt_t = PC_IDLE;
    c.tgt_f = PC_IDLE;
    case (pc)
      PC_PUT0: begin
        c.frd = FRD_F1;
        c.brd = BRD_F;
        c.stk = STK_PUSH;
        c.res = RES_PUT;
        c.cnd = CND_QUIT;
        c.tgt_f = PC_SPL1;
      end
      PC_SPL1: begin
        c.frd = FRD_IDX;
        c.brd = BRD_HI;
        c.lat = 1'b1;
        c.tgt_f = PC_SPL2;
      end
      PC_SPL2: begin
        c.wr = 1'b1;
        c.cnd = CND_ALWAYS;
      end
      PC_UND0: begin
        c.stk = STK_POP;
        c.res = RES_UNDO_CHK;
        c.cnd = CND_QUIT;
        c.tgt_f = PC_UND1;
      end
      PC_UND1: begin
        c.fsrc = 1'b1;
        c.frd = FRD_F1;
        c.brd = BRD_F;
        c.res = RES_UNDO_F;
        c.cnd = CND_QUIT;
        c.tgt_f = PC_SPL1;
      end
      PC_FST0: begin
        c.frd = FRD_HEAD;
        c.tgt_f = PC_FST1;
      end
      PC_FST1: begin
        c.res = RES_FIRST;
        c.cnd = CND_ALWAYS;
      end
      PC_NXT0: begin
        c.frd = FRD_F1;
        c.res = RES_NEXT_CHK;
        c.cnd = CND_QUIT;
        c.tgt_f = PC_NXT1;
      end
      PC_NXT1: begin
        c.res = RES_NEXT;
        c.cnd = CND_ALWAYS;
      end
      default: begin
        c.cnd = CND_NEVER;
      end
    endcase
    return c;
  endfunction

  function automatic logic [PC_W-1:0] entry(input logic [OP_W-1:0] op);
    logic [PC_W-1:0] pc;
    case (op)
      OP_PUT:   pc = PC_PUT0;
      OP_UNDO:  pc = PC_UND0;
      OP_FIRST: pc = PC_FST0;
      OP_NEXT:  pc = PC_NXT0;
      default:  pc = PC_IDLE;
    endcase
    return pc;
  endfunction

endpackage

// ===== rtl/fssu_dist_mem.sv =====
// Distance table: registered-read memory whose unwritten entries read as one.
module fssu_dist_mem (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fssu_pkg::tbl_req_t     req,
  output logic [fssu_pkg::PW-1:0] rd_data
);
  import fssu_pkg::*;

  logic [PW-1:0]    mem_r [0:DEPTH-1];
  logic [DEPTH-1:0] vld_r;
  logic [PW-1:0]    rd_data_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (req.rd_en) begin
      rd_vld_r <= vld_r[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : PW'(1);

endmodule

// ===== rtl/fssu_seq.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module fssu_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [fssu_pkg::OP_W-1:0]    op,
  input  logic                         quit,
  input  logic                         out_block,
  output logic                         in_stall,
  output fssu_pkg::ctrl_t              ctl,
  output fssu_pkg::seq_stat_t          sst
);
  import fssu_pkg::*;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic [PC_W-1:0] tgt;
  logic            taken;
  logic            busy;
  logic            last;
  logic            step_en;
  logic            done;
  logic            accept;

  assign ctl = ucode(pc_r);

  always_comb begin
    case (ctl.cnd)
      CND_ALWAYS: taken = 1'b1;
      CND_QUIT:   taken = quit;
      default:    taken = 1'b0;
    endcase
  end

  assign tgt     = taken ? ctl.tgt_t : ctl.tgt_f;
  assign busy    = (pc_r != PC_IDLE);
  assign last    = (tgt == PC_IDLE);
  // The last step loads the output register, so it waits while that register is held.
  assign step_en = busy && !(last && out_block);
  assign done    = step_en && last;
  assign in_stall = busy && !done;
  assign accept  = in_valid && !in_stall;

  always_comb begin
    if (accept) begin
      pc_nxt = entry(op);
    end else if (step_en) begin
      pc_nxt = tgt;
    end else begin
      pc_nxt = pc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign sst.accept  = accept;
  assign sst.step_en = step_en;
  assign sst.done    = done;

endmodule

// ===== rtl/free_slot_set_with_undo.sv =====
// Free slot set with undo: the free slots form a chain of forward and backward skip
// distances kept in two 65-entry tables; a take splices a slot out and pushes it on an
// undo stack, an undo pops and splices it back, and two queries walk the chain. A
// microprogram sequences the work, at most one read per table per step, with
// registered read data: a take runs the put and splice steps, an undo a pop and a
// reinsert step before those, a query a read and a result step, and errors end after
// the first step. A new item is taken in the last step of the current one; the result
// sits in an output register until taken, and while it is held the last step of the
// next item waits. The tables are ready after reset, as unwritten entries read as one.
module free_slot_set_with_undo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  fssu_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output fssu_pkg::out_item_t   out_data
);
  import fssu_pkg::*;

  ctrl_t      ctl;
  seq_stat_t  sst;
  tbl_req_t   fwd_req;
  tbl_req_t   bwd_req;
  logic [PW-1:0] fwd_rd;
  logic [PW-1:0] bwd_rd;

  logic [OP_W-1:0]   op_r;
  logic [SLOT_W-1:0] f_r;
  logic [PW-1:0]     p_r;
  logic [PW-1:0]     n_r;
  logic [PW-1:0]     i_r;
  logic [PW-1:0]     hi_r;
  logic              lo_ok_r;
  logic              hi_ok_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [PW-1:0]     res_r;
  logic [PW-1:0]     res_nxt;
  logic [ST_W-1:0]   st_r;
  logic [ST_W-1:0]   st_nxt;
  logic              quit;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [SLOT_W-1:0] stk_mem_r [0:SLOTS-1];
  logic [SLOT_W-1:0] stk_rd_r;
  logic [CNT_W-1:0]  cnt_m1;
  logic              push_en;
  logic              pop_en;

  logic [SLOT_W-1:0] f_src;
  logic [PW-1:0]     f_pos;
  logic [PW-1:0]     f1_pos;
  logic              lo_ok;
  logic [PW-1:0]     i_val;
  logic [HI_W-1:0]   hi_sum;
  logic              hi_ok;
  logic              room;
  logic              f_oor;
  logic              add;

  fssu_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .op        (in_data.operation),
    .quit      (quit),
    .out_block (out_valid_r && out_stall),
    .in_stall  (in_stall),
    .ctl       (ctl),
    .sst       (sst)
  );

  fssu_dist_mem u_fwd (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (fwd_req),
    .rd_data (fwd_rd)
  );

  fssu_dist_mem u_bwd (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (bwd_req),
    .rd_data (bwd_rd)
  );

  // Slot s sits at table position s + 1; position 0 is the head.
  assign f_src  = ctl.fsrc ? stk_rd_r : f_r;
  assign f_pos  = PW'(f_src);
  assign f1_pos = f_pos + PW'(1);
  assign lo_ok  = (f1_pos >= bwd_rd);
  assign i_val  = f1_pos - bwd_rd;
  assign hi_sum = HI_W'(f_pos) + HI_W'(fwd_rd);
  assign hi_ok  = (hi_sum <= HI_W'(SLOTS));
  assign room   = (cnt_r < CNT_W'(SLOTS));
  assign f_oor  = (f_pos >= PW'(SLOTS));
  assign add    = (op_r == OP_PUT);
  assign cnt_m1 = cnt_r - CNT_W'(1);

  always_comb begin
    fwd_req.rd_en = sst.step_en && (ctl.frd != FRD_NONE);
    case (ctl.frd)
      FRD_F1:  fwd_req.rd_addr = f1_pos;
      FRD_IDX: fwd_req.rd_addr = lo_ok ? i_val : '0;
      default: fwd_req.rd_addr = '0;
    endcase
    fwd_req.wr_en   = sst.step_en && ctl.wr && lo_ok_r;
    fwd_req.wr_addr = i_r;
    fwd_req.wr_data = add ? fwd_rd + n_r : fwd_rd - n_r;
  end

  always_comb begin
    bwd_req.rd_en = sst.step_en && (ctl.brd != BRD_NONE);
    case (ctl.brd)
      BRD_F:   bwd_req.rd_addr = f_pos;
      BRD_HI:  bwd_req.rd_addr = hi_ok ? hi_sum[PW-1:0] : '0;
      default: bwd_req.rd_addr = '0;
    endcase
    bwd_req.wr_en   = sst.step_en && ctl.wr && hi_ok_r;
    bwd_req.wr_addr = hi_r;
    bwd_req.wr_data = add ? bwd_rd + p_r : bwd_rd - p_r;
  end

  // Result unit. Quit marks an operation that ends here, with or without an error.
  always_comb begin
    res_nxt = res_r;
    st_nxt  = st_r;
    quit    = 1'b0;
    case (ctl.res)
      RES_PUT: begin
        res_nxt = PW'(SLOTS);
        quit    = 1'b1;
        if (!room) begin
          st_nxt = ST_FULL;
        end else if (f_oor) begin
          st_nxt = ST_RANGE;
        end else begin
          res_nxt = f_pos;
          st_nxt  = ST_OK;
          quit    = 1'b0;
        end
      end
      RES_UNDO_CHK: begin
        st_nxt = ST_OK;
        if (cnt_r == '0) begin
          res_nxt = PW'(SLOTS);
          st_nxt  = ST_EMPTY;
          quit    = 1'b1;
        end
      end
      RES_UNDO_F: begin
        res_nxt = f_pos;
        st_nxt  = ST_OK;
        quit    = f_oor;
      end
      RES_FIRST: begin
        st_nxt = ST_OK;
        if ((fwd_rd != '0) && ((fwd_rd - PW'(1)) <= PW'(SLOTS))) begin
          res_nxt = fwd_rd - PW'(1);
        end else begin
          res_nxt = PW'(SLOTS);
        end
      end
      RES_NEXT_CHK: begin
        res_nxt = PW'(SLOTS);
        st_nxt  = ST_OK;
        if (f_oor) begin
          st_nxt = ST_RANGE;
          quit   = 1'b1;
        end
      end
      RES_NEXT: begin
        st_nxt = ST_OK;
        if (hi_sum > HI_W'(SLOTS)) begin
          res_nxt = PW'(SLOTS);
        end else begin
          res_nxt = hi_sum[PW-1:0];
        end
      end
      default: begin
        quit = 1'b0;
      end
    endcase
  end

  assign push_en = sst.step_en && (ctl.stk == STK_PUSH) && room && !f_oor;
  assign pop_en  = sst.step_en && (ctl.stk == STK_POP) && (cnt_r != '0);

  always_comb begin
    if (push_en) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop_en) begin
      cnt_nxt = cnt_m1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      stk_mem_r[cnt_r[SLOT_W-1:0]] <= f_src;
    end
    if (pop_en) begin
      stk_rd_r <= stk_mem_r[cnt_m1[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sst.accept) begin
      op_r <= in_data.operation;
      f_r  <= in_data.field_index;
    end else if (sst.step_en && ctl.fsrc) begin
      f_r <= stk_rd_r;
    end
    if (sst.step_en && ctl.lat) begin
      p_r     <= bwd_rd;
      n_r     <= fwd_rd;
      i_r     <= i_val;
      hi_r    <= hi_sum[PW-1:0];
      lo_ok_r <= lo_ok;
      hi_ok_r <= hi_ok;
    end
    if (sst.step_en) begin
      res_r <= res_nxt;
      st_r  <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sst.done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sst.done) begin
      out_data_r.field_out  <= res_nxt;
      out_data_r.free_count <= CNT_W'(SLOTS) - cnt_nxt;
      out_data_r.status     <= st_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A new result appears only from the last step of an operation.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(sst.done))
    else $error("result raised without a finishing step");

  // After a transfer in, the block is busy for at least one step.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    sst.accept |=> in_stall || sst.done)
    else $error("input taken again without a step in between");

  // The take count moves only while a step runs.
  a_cnt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !sst.step_en |=> $stable(cnt_r))
    else $error("take count changed outside a step");

  // The reported free count never exceeds the slot count.
  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.free_count <= CNT_W'(SLOTS)))
    else $error("free count out of range");

endmodule
